// ===== design/mbrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types, constants and the CRC-16 byte step of the Modbus RTU slave.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrtu_pkg;

	// sizes
	localparam int FRAME_BYTES    = 16;
	localparam int HOLD_REGS      = 8;
	localparam int REPLY_OVERHEAD = 5;
	localparam int MAX_REPLY      = REPLY_OVERHEAD + 2 * HOLD_REGS;

	localparam int BUF_IDX_W = $clog2(FRAME_BYTES);
	localparam int CNT_W     = $clog2(FRAME_BYTES + 1);
	localparam int REG_IDX_W = $clog2(HOLD_REGS);
	localparam int QTY_W     = $clog2(HOLD_REGS + 1);
	localparam int KW        = $clog2(MAX_REPLY + 1);

	// protocol constants
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [7:0]  FUNC_READ = 8'h03;

	// item kinds
	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_SLAVE_ADDR = 1'b0,
		CFG_SILENCE    = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  rx_byte;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
	} in_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic check_step;
		logic frame_clear;
		logic reply_start;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame_end;
		logic walk_done;
		logic frame_ok;
		logic out_free;
		logic final_byte;
	} dp_status_t;

	// one byte through the reflected crc-16
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/mbrtu_dp.sv =====
// ----------------------------------------------------------------------------
// mbrtu_dp
// Frame buffer, holding registers, silence counter, crc unit and reply
// byte register of the Modbus RTU slave.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mbrtu_pkg::in_t       in_data,
	input  wire mbrtu_pkg::dp_cmd_t   cmd,
	input  wire logic                 cfg_we,
	input  wire logic [0:0]           cfg_index,
	input  wire logic [7:0]           cfg_wdata,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output mbrtu_pkg::out_t           out_data,
	output mbrtu_pkg::dp_status_t     status
);

	logic [7:0]  slave_addr_q;
	logic [7:0]  silence_ticks_q;
	logic [7:0]  frame_buf_q [mbrtu_pkg::FRAME_BYTES];
	logic [15:0] hold_q [mbrtu_pkg::HOLD_REGS];
	logic [mbrtu_pkg::CNT_W-1:0] count_q;
	logic [7:0]  silence_q;
	logic        out_valid_q;

	logic [15:0] crc_q;
	logic [mbrtu_pkg::CNT_W-1:0] walk_q;
	logic [mbrtu_pkg::KW-1:0]    k_q;
	logic [mbrtu_pkg::QTY_W-1:0] qty_q;
	mbrtu_pkg::out_t             out_data_q;

	logic [7:0]  silence_next;
	logic [15:0] qty_raw;
	logic [mbrtu_pkg::QTY_W-1:0] qty_clamped;
	logic [mbrtu_pkg::KW-1:0]    reply_len;
	logic [mbrtu_pkg::KW-1:0]    reg_off;
	logic [mbrtu_pkg::REG_IDX_W-1:0] reg_sel;
	logic        is_crc_lo;
	logic        is_crc_hi;
	logic [7:0]  reply_byte;
	logic [15:0] reg_word;

	// saturating silence increment, used by the end of frame detect
	assign silence_next = (silence_q == 8'hFF) ? silence_q : silence_q + 8'd1;

	// quantity from bytes 4 and 5, clamped to the register count
	assign qty_raw     = {frame_buf_q[4], frame_buf_q[5]};
	assign qty_clamped = (qty_raw > 16'(mbrtu_pkg::HOLD_REGS)) ?
		mbrtu_pkg::QTY_W'(mbrtu_pkg::HOLD_REGS) : qty_raw[mbrtu_pkg::QTY_W-1:0];

	// reply byte selection
	assign reply_len = mbrtu_pkg::KW'(mbrtu_pkg::REPLY_OVERHEAD)
		+ mbrtu_pkg::KW'(qty_q) + mbrtu_pkg::KW'(qty_q);
	assign is_crc_hi = (k_q == reply_len - mbrtu_pkg::KW'(1));
	assign is_crc_lo = (k_q == reply_len - mbrtu_pkg::KW'(2));
	assign reg_off   = k_q - mbrtu_pkg::KW'(3);
	assign reg_sel   = reg_off[mbrtu_pkg::REG_IDX_W:1];
	assign reg_word  = hold_q[reg_sel];

	always_comb begin
		priority if (k_q == mbrtu_pkg::KW'(0)) begin
			reply_byte = frame_buf_q[0];
		end else if (k_q == mbrtu_pkg::KW'(1)) begin
			reply_byte = mbrtu_pkg::FUNC_READ;
		end else if (k_q == mbrtu_pkg::KW'(2)) begin
			reply_byte = 8'({qty_q, 1'b0});
		end else if (is_crc_hi) begin
			reply_byte = crc_q[15:8];
		end else if (is_crc_lo) begin
			reply_byte = crc_q[7:0];
		end else if (!reg_off[0]) begin
			reply_byte = reg_word[15:8];
		end else begin
			reply_byte = reg_word[7:0];
		end
	end

	// status to the controller
	always_comb begin
		status.frame_end  = (mbrtu_pkg::cmd_t'(in_data.cmd) == mbrtu_pkg::CMD_TICK)
			&& (count_q != '0) && (silence_next >= silence_ticks_q);
		status.walk_done  = (walk_q == count_q);
		status.frame_ok   = (frame_buf_q[0] == slave_addr_q) && (crc_q == 16'h0000)
			&& (frame_buf_q[1] == mbrtu_pkg::FUNC_READ);
		status.out_free   = !out_valid_q || out_ready;
		status.final_byte = is_crc_hi;
	end

	// configuration, frame store, counters and holding registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q    <= 8'd1;
			silence_ticks_q <= 8'd9;
			count_q         <= '0;
			silence_q       <= '0;
			for (int i = 0; i < mbrtu_pkg::FRAME_BYTES; i++) begin
				frame_buf_q[i] <= '0;
			end
			for (int i = 0; i < mbrtu_pkg::HOLD_REGS; i++) begin
				hold_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (mbrtu_pkg::cfg_idx_t'(cfg_index))
					mbrtu_pkg::CFG_SLAVE_ADDR: slave_addr_q    <= cfg_wdata;
					mbrtu_pkg::CFG_SILENCE:    silence_ticks_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				unique case (mbrtu_pkg::cmd_t'(in_data.cmd))
					mbrtu_pkg::CMD_BYTE: begin
						if (count_q < mbrtu_pkg::CNT_W'(mbrtu_pkg::FRAME_BYTES)) begin
							frame_buf_q[count_q[mbrtu_pkg::BUF_IDX_W-1:0]] <= in_data.rx_byte;
							count_q <= count_q + mbrtu_pkg::CNT_W'(1);
						end
						silence_q <= '0;
					end
					mbrtu_pkg::CMD_TICK: begin
						if (count_q != '0) begin
							silence_q <= silence_next;
						end
					end
					mbrtu_pkg::CMD_WRITE: begin
						if (int'(in_data.reg_index) < mbrtu_pkg::HOLD_REGS) begin
							hold_q[in_data.reg_index[mbrtu_pkg::REG_IDX_W-1:0]] <=
								in_data.reg_value;
						end
					end
					mbrtu_pkg::CMD_NONE: ;
					default: ;
				endcase
			end
			if (cmd.frame_clear) begin
				count_q   <= '0;
				silence_q <= '0;
			end
		end
	end

	// crc walk over the stored frame, then reply sequencing
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			crc_q  <= mbrtu_pkg::CRC_INIT;
			walk_q <= '0;
		end else if (cmd.check_step) begin
			crc_q  <= mbrtu_pkg::crc_add(crc_q, frame_buf_q[walk_q[mbrtu_pkg::BUF_IDX_W-1:0]]);
			walk_q <= walk_q + mbrtu_pkg::CNT_W'(1);
		end else if (cmd.reply_start) begin
			crc_q <= mbrtu_pkg::CRC_INIT;
			k_q   <= '0;
			qty_q <= qty_clamped;
		end else if (cmd.emit) begin
			if (!is_crc_lo && !is_crc_hi) begin
				crc_q <= mbrtu_pkg::crc_add(crc_q, reply_byte);
			end
			k_q <= k_q + mbrtu_pkg::KW'(1);
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q.tx_byte <= reply_byte;
			out_data_q.last    <= is_crc_hi;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== design/mbrtu_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbrtu_ctrl
// Sequencer of the Modbus RTU slave: idle, frame check, reply.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire mbrtu_pkg::dp_status_t status,
	output mbrtu_pkg::dp_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CHECK = 3'b010,
		ST_REPLY = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && status.frame_end) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!status.walk_done) begin
					cmd.check_step = 1'b1;
				end else begin
					cmd.frame_clear = 1'b1;
					if (status.frame_ok) begin
						cmd.reply_start = 1'b1;
						state_d = ST_REPLY;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_REPLY: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.final_byte) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/modbus_rtu_read_holding_slave.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_read_holding_slave
// Modbus RTU slave answering function 3 (read holding registers).
// ----------------------------------------------------------------------------
// Input words carry one of: a received line byte, a silence timer tick, or a
// holding register write. Output words are the reply bytes, with last set on
// the crc high byte. Both channels use valid/ready; config is a plain write
// port (index 0 slave address, index 1 silence tick count) used while idle.
//
// A byte, write or non-final tick is taken while idle. The tick that ends a
// frame starts a crc walk over each stored byte (up to 16) through a byte-wide
// crc register, then the frame is checked and cleared. An answered frame then
// emits 5 + 2*quantity bytes, one per cycle while the receiver keeps ready
// high; the reply crc runs through the same register as bytes leave.
// Input is held off (in_ready low) during check and reply. A stalled receiver
// holds the reply sequencer; the final reply byte may still wait in the
// output register while new input words are taken.
// Reset clears the frame buffer, holding registers, byte and silence counters
// and loads slave address 1 and silence count 9; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_read_holding_slave (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire mbrtu_pkg::in_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output mbrtu_pkg::out_t      out_data,
	input  wire logic            cfg_we,
	input  wire logic [0:0]      cfg_index,
	input  wire logic [7:0]      cfg_wdata
);

	mbrtu_pkg::dp_cmd_t    dp_cmd;
	mbrtu_pkg::dp_status_t dp_status;

	// sequencer
	mbrtu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	// frame store, crc and reply path
	mbrtu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (dp_cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.status    (dp_status)
	);

endmodule

`default_nettype wire
